FILE: rtl/llq_pkg.sv
package llq_pkg;

  // Pool and pair counts; the node and pair fields cover them exactly.
  localparam int POOL_SIZE  = 64;
  localparam int PAIR_COUNT = 8;
  localparam int NODE_W     = 6;
  localparam int PAIR_W     = 3;
  localparam int CNT_W      = 7;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_ENQ   = 2'd1,
    FUNC_MOVE  = 2'd2,
    FUNC_REL   = 2'd3
  } func_e;

  // One input word as held in the item register.
  typedef struct packed {
    func_e              func;
    logic [NODE_W-1:0]  node_id;
    logic [PAIR_W-1:0]  pair_id;
  } item_t;

  // Head, tail and non-empty flag of one linked queue.
  typedef struct packed {
    logic [NODE_W-1:0] head;
    logic [NODE_W-1:0] tail;
    logic              valid;
  } fifo_ptrs_t;

  // Link memory read request.
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } link_rd_t;

  // Link memory write request.
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } link_wr_t;

  // One result word.
  typedef struct packed {
    logic              status;
    logic [NODE_W-1:0] node;
  } result_t;

endpackage

FILE: rtl/llq_ram.sv
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/llq_link.sv
module llq_link (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  llq_pkg::link_rd_t         rd_i,
  input  llq_pkg::link_wr_t         wr_i,
  output logic [llq_pkg::NODE_W-1:0] link_o
);

  logic [llq_pkg::POOL_SIZE-1:0] written_q;
  logic                          sel_written_q;
  logic [llq_pkg::NODE_W-1:0]    raddr_q;
  logic [llq_pkg::NODE_W-1:0]    rdata;
  logic [llq_pkg::NODE_W-1:0]    succ;

  llq_ram #(
    .WIDTH (llq_pkg::NODE_W),
    .DEPTH (llq_pkg::POOL_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.addr),
    .rdata_o (rdata)
  );

  // An entry counts as written once the memory holds a real link for it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.en) begin
      written_q[wr_i.addr] <= 1'b1;
    end
  end

  // Track the read address and whether it was written, alongside the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_written_q <= 1'b0;
      raddr_q       <= '0;
    end else if (rd_i.en) begin
      sel_written_q <= written_q[rd_i.addr];
      raddr_q       <= rd_i.addr;
    end
  end

  // An unwritten entry links to its successor, wrapping at the pool end.
  assign succ = (raddr_q == llq_pkg::NODE_W'(llq_pkg::POOL_SIZE - 1)) ? '0
              : raddr_q + llq_pkg::NODE_W'(1);

  assign link_o = sel_written_q ? rdata : succ;

endmodule

FILE: rtl/llq_core.sv
module llq_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       issue_i,
  input  llq_pkg::func_e             func_i,
  input  logic [llq_pkg::PAIR_W-1:0] pair_i,
  input  logic                       commit_i,
  input  llq_pkg::item_t             item_i,
  input  logic [llq_pkg::NODE_W-1:0] link_i,
  output llq_pkg::link_rd_t          rd_o,
  output llq_pkg::link_wr_t          wr_o,
  output llq_pkg::result_t           result_o
);

  llq_pkg::fifo_ptrs_t pend_q [llq_pkg::PAIR_COUNT];
  llq_pkg::fifo_ptrs_t act_q  [llq_pkg::PAIR_COUNT];
  logic [llq_pkg::NODE_W-1:0] free_head_q, free_head_d;
  logic [llq_pkg::NODE_W-1:0] free_tail_q, free_tail_d;
  logic [llq_pkg::CNT_W-1:0]  free_cnt_q, free_cnt_d;

  llq_pkg::fifo_ptrs_t pq, aq, pq_d, aq_d;
  llq_pkg::link_wr_t   wr;
  llq_pkg::result_t    res;
  logic [llq_pkg::NODE_W-1:0] rd_addr;

  // Read the link of the head that the operation will take.
  always_comb begin
    case (func_i)
      llq_pkg::FUNC_ALLOC: rd_addr = free_head_q;
      llq_pkg::FUNC_MOVE:  rd_addr = pend_q[pair_i].head;
      llq_pkg::FUNC_REL:   rd_addr = act_q[pair_i].head;
      default:             rd_addr = free_head_q;
    endcase
  end

  assign rd_o = '{en: issue_i, addr: rd_addr};

  // Next state of the lists for the held word, using the link read when it was taken.
  always_comb begin
    pq          = pend_q[item_i.pair_id];
    aq          = act_q[item_i.pair_id];
    pq_d        = pq;
    aq_d        = aq;
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    free_cnt_d  = free_cnt_q;
    wr          = '0;
    res         = '{status: 1'b1, node: '0};
    case (item_i.func)
      llq_pkg::FUNC_ALLOC: begin
        if (free_cnt_q != '0) begin
          res        = '{status: 1'b0, node: free_head_q};
          free_cnt_d = free_cnt_q - llq_pkg::CNT_W'(1);
          if (free_cnt_d != '0) begin
            free_head_d = link_i;
          end
        end
      end
      llq_pkg::FUNC_ENQ: begin
        res = '{status: 1'b0, node: item_i.node_id};
        if (pq.valid) begin
          wr = '{en: 1'b1, addr: pq.tail, data: item_i.node_id};
        end else begin
          pq_d.head = item_i.node_id;
        end
        pq_d.tail  = item_i.node_id;
        pq_d.valid = 1'b1;
      end
      llq_pkg::FUNC_MOVE: begin
        if (pq.valid) begin
          res = '{status: 1'b0, node: pq.head};
          // Pop the pending head.
          if (pq.head == pq.tail) begin
            pq_d.valid = 1'b0;
          end else begin
            pq_d.head = link_i;
          end
          // Push it onto the active queue.
          if (aq.valid) begin
            wr = '{en: 1'b1, addr: aq.tail, data: pq.head};
          end else begin
            aq_d.head = pq.head;
          end
          aq_d.tail  = pq.head;
          aq_d.valid = 1'b1;
        end
      end
      llq_pkg::FUNC_REL: begin
        if (aq.valid) begin
          res = '{status: 1'b0, node: aq.head};
          // Pop the active head.
          if (aq.head == aq.tail) begin
            aq_d.valid = 1'b0;
          end else begin
            aq_d.head = link_i;
          end
          // Return it to the free list tail; the count saturates at the pool size.
          if (free_cnt_q == '0) begin
            free_head_d = aq.head;
          end else begin
            wr = '{en: 1'b1, addr: free_tail_q, data: aq.head};
          end
          free_tail_d = aq.head;
          if (free_cnt_q < llq_pkg::CNT_W'(llq_pkg::POOL_SIZE)) begin
            free_cnt_d = free_cnt_q + llq_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        res = '{status: 1'b1, node: '0};
      end
    endcase
  end

  assign wr_o     = commit_i ? wr : '0;
  assign result_o = res;

  // Queue pointer state; all queues start empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < llq_pkg::PAIR_COUNT; i++) begin
        pend_q[i] <= '0;
        act_q[i]  <= '0;
      end
    end else if (commit_i) begin
      pend_q[item_i.pair_id] <= pq_d;
      act_q[item_i.pair_id]  <= aq_d;
    end
  end

  // Free list state; it starts with every node in index order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_tail_q <= llq_pkg::NODE_W'(llq_pkg::POOL_SIZE - 1);
      free_cnt_q  <= llq_pkg::CNT_W'(llq_pkg::POOL_SIZE);
    end else if (commit_i) begin
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      free_cnt_q  <= free_cnt_d;
    end
  end

endmodule

FILE: rtl/linked_list_queue_manager.sv
// Linked-list queue manager: free list plus pending and active queues per pair.
// A result word passes from the item register to the output register; it is
// valid once the held word commits and the output register loads.
// No new word is taken while one is held, so each word does its link memory
// read of the taken head and then its link write of the appended tail.
// Reset (asynchronous, active low): all nodes on the free list in index order,
// every queue empty, link entries read as their successor until written.
module linked_list_queue_manager (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 func_i,
  input  logic [llq_pkg::NODE_W-1:0] node_id_i,
  input  logic [llq_pkg::PAIR_W-1:0] pair_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic [llq_pkg::NODE_W-1:0] node_out_o
);

  logic                       busy_q;
  llq_pkg::item_t             item_q;
  logic                       out_valid_q;
  llq_pkg::result_t           out_q;
  logic                       accept;
  logic                       commit;
  logic                       out_free;
  llq_pkg::link_rd_t          link_rd;
  llq_pkg::link_wr_t          link_wr;
  logic [llq_pkg::NODE_W-1:0] link;
  llq_pkg::result_t           result;

  // A word is taken when no word is held; the held word finishes once the
  // output register can load.
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = busy_q && out_free;

  // Item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (commit) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{func: llq_pkg::func_e'(func_i), node_id: node_id_i, pair_id: pair_id_i};
    end
  end

  llq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (accept),
    .func_i   (llq_pkg::func_e'(func_i)),
    .pair_i   (pair_id_i),
    .commit_i (commit),
    .item_i   (item_q),
    .link_i   (link),
    .rd_o     (link_rd),
    .wr_o     (link_wr),
    .result_o (result)
  );

  llq_link u_link (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (link_rd),
    .wr_i   (link_wr),
    .link_o (link)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign node_out_o  = out_q.node;

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 300000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 func_i = llq_pkg::FUNC_ALLOC;
  logic [llq_pkg::NODE_W-1:0] node_id_i = '0;
  logic [llq_pkg::PAIR_W-1:0] pair_id_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       status_o;
  logic [llq_pkg::NODE_W-1:0] node_out_o;

  // Shadow copy of the link memory, free list and queue pointers.
  logic [llq_pkg::NODE_W-1:0] link_mem [llq_pkg::POOL_SIZE];
  logic [llq_pkg::NODE_W-1:0] free_head;
  logic [llq_pkg::NODE_W-1:0] free_tail;
  logic [llq_pkg::CNT_W-1:0]  free_cnt;
  llq_pkg::fifo_ptrs_t        pend_q [llq_pkg::PAIR_COUNT];
  llq_pkg::fifo_ptrs_t        act_q [llq_pkg::PAIR_COUNT];

  llq_pkg::result_t           predicted_words [$];
  logic [llq_pkg::NODE_W-1:0] held_nodes [$];
  llq_pkg::result_t           head_word;
  int                         mismatch_count = 0;
  int                         cycle_count = 0;
  int                         idle_pct = 0;
  int                         stall_pct = 0;

  linked_list_queue_manager uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .node_id_i   (node_id_i),
    .pair_id_i   (pair_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .node_out_o  (node_out_o)
  );

  always #5 clk_i = ~clk_i;

  // The run is cut off if it takes far longer than any correct run could.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Puts the shadow state into its reset condition.
  function automatic void reset_shadow();
    for (int i = 0; i < llq_pkg::POOL_SIZE; i++) begin
      link_mem[i] = llq_pkg::NODE_W'((i + 1) % llq_pkg::POOL_SIZE);
    end
    free_head = '0;
    free_tail = llq_pkg::NODE_W'(llq_pkg::POOL_SIZE - 1);
    free_cnt = llq_pkg::CNT_W'(llq_pkg::POOL_SIZE);
    for (int p = 0; p < llq_pkg::PAIR_COUNT; p++) begin
      pend_q[p] = '0;
      act_q[p] = '0;
    end
  endfunction

  // Appends a node at the tail of a queue, linking the old tail to it.
  function automatic llq_pkg::fifo_ptrs_t append_node(llq_pkg::fifo_ptrs_t q,
                                                      logic [llq_pkg::NODE_W-1:0] n);
    if (q.valid) link_mem[q.tail] = n;
    else q.head = n;
    q.tail = n;
    q.valid = 1'b1;
    return q;
  endfunction

  // Removes the head of a non-empty queue; taking the tail empties it.
  function automatic llq_pkg::fifo_ptrs_t drop_head(llq_pkg::fifo_ptrs_t q);
    if (q.head == q.tail) q.valid = 1'b0;
    else q.head = link_mem[q.head];
    return q;
  endfunction

  // Applies one operation to the shadow state and returns the word it yields.
  // The node and pair fields cover the pool and the pairs exactly, so no
  // handle can be out of range here.
  function automatic llq_pkg::result_t apply_queue_op(llq_pkg::func_e op,
                                                      logic [llq_pkg::NODE_W-1:0] node,
                                                      logic [llq_pkg::PAIR_W-1:0] pair);
    llq_pkg::result_t           r;
    logic [llq_pkg::NODE_W-1:0] taken;
    logic                       ok;
    taken = '0;
    ok = 1'b0;
    case (op)
      llq_pkg::FUNC_ALLOC: begin
        if (free_cnt != 0) begin
          taken = free_head;
          free_cnt = free_cnt - 1'b1;
          if (free_cnt != 0) free_head = link_mem[taken];
          ok = 1'b1;
        end
      end
      llq_pkg::FUNC_ENQ: begin
        pend_q[pair] = append_node(pend_q[pair], node);
        taken = node;
        ok = 1'b1;
      end
      llq_pkg::FUNC_MOVE: begin
        if (pend_q[pair].valid) begin
          taken = pend_q[pair].head;
          pend_q[pair] = drop_head(pend_q[pair]);
          act_q[pair] = append_node(act_q[pair], taken);
          ok = 1'b1;
        end
      end
      default: begin
        if (act_q[pair].valid) begin
          taken = act_q[pair].head;
          act_q[pair] = drop_head(act_q[pair]);
          if (free_cnt == 0) free_head = taken;
          else link_mem[free_tail] = taken;
          free_tail = taken;
          // The count saturates when a trusted handle was put back twice.
          if (free_cnt < llq_pkg::POOL_SIZE) free_cnt = free_cnt + 1'b1;
          ok = 1'b1;
        end
      end
    endcase
    r.status = ~ok;
    r.node = ok ? taken : '0;
    return r;
  endfunction

  // Sends one word, after random idle cycles, and records its prediction.
  // Entered and left at a falling edge; valid stays high for a following word.
  task automatic send_word(input llq_pkg::func_e op, input logic [llq_pkg::NODE_W-1:0] node,
                           input logic [llq_pkg::PAIR_W-1:0] pair,
                           output llq_pkg::result_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    node_id_i <= node;
    pair_id_i <= pair;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_queue_op(op, node, pair);
    predicted_words.push_back(r);
    @(negedge clk_i);
  endtask

  // Holds the input side idle until every predicted word has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (predicted_words.size() != 0) @(negedge clk_i);
  endtask

  // Every result word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %b node %0d", status_o, node_out_o));
      end else begin
        head_word = predicted_words.pop_front();
        if (status_o !== head_word.status)
          report_mismatch($sformatf("status %b, predicted %b", status_o, head_word.status));
        if (node_out_o !== head_word.node)
          report_mismatch($sformatf("node %0d, predicted %0d", node_out_o, head_word.node));
      end
    end
  end

  // Picks a pair, preferring one whose pending or active queue holds a node.
  function automatic logic [llq_pkg::PAIR_W-1:0] pick_pair(bit from_active);
    logic [llq_pkg::PAIR_W-1:0] p;
    p = '0;
    for (int k = 0; k < 4; k++) begin
      p = llq_pkg::PAIR_W'($urandom_range(0, llq_pkg::PAIR_COUNT - 1));
      if (from_active ? act_q[p].valid : pend_q[p].valid) return p;
    end
    return p;
  endfunction

  // Each operation on non-empty lists, move and release on empty queues, both
  // ends of the pair range, a queue emptied at its tail, and a trusted handle that is already free.
  task automatic test_each_operation();
    llq_pkg::result_t r;
    send_word(llq_pkg::FUNC_MOVE, 6'd63, 3'd0, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd7, r);
    send_word(llq_pkg::FUNC_ALLOC, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_ALLOC, 6'd63, 3'd7, r);
    send_word(llq_pkg::FUNC_ALLOC, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_ENQ, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_ENQ, 6'd1, 3'd0, r);
    send_word(llq_pkg::FUNC_ENQ, 6'd2, 3'd7, r);
    send_word(llq_pkg::FUNC_MOVE, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_MOVE, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_MOVE, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_MOVE, 6'd0, 3'd7, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd0, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd7, r);
    send_word(llq_pkg::FUNC_REL, 6'd0, 3'd7, r);
    send_word(llq_pkg::FUNC_ENQ, 6'd63, 3'd3, r);
    send_word(llq_pkg::FUNC_MOVE, 6'd0, 3'd3, r);
    send_word(llq_pkg::FUNC_REL, 6'd63, 3'd3, r);
    send_word(llq_pkg::FUNC_ALLOC, 6'd0, 3'd5, r);
    held_nodes.push_back(r.node);
  endtask

  // Allocates past the end of the free list; the last words find it empty.
  task automatic test_free_list_exhaustion();
    llq_pkg::result_t r;
    for (int i = 0; i < llq_pkg::POOL_SIZE + 2; i++) begin
      send_word(llq_pkg::FUNC_ALLOC, llq_pkg::NODE_W'($urandom_range(0, 63)),
                llq_pkg::PAIR_W'($urandom_range(0, 7)), r);
      if (!r.status) held_nodes.push_back(r.node);
    end
  endtask

  // Mostly well-formed node lifecycles with random pairs, plus random noise.
  task automatic test_random_ops(input int count, input int idle, input int stall);
    llq_pkg::result_t           r;
    llq_pkg::func_e             op;
    logic [llq_pkg::NODE_W-1:0] node;
    logic [llq_pkg::PAIR_W-1:0] pair;
    int                         sel;
    int                         idx;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      node = llq_pkg::NODE_W'($urandom_range(0, 63));
      pair = llq_pkg::PAIR_W'($urandom_range(0, 7));
      if (sel < 8) begin
        op = llq_pkg::func_e'($urandom_range(0, 3));
      end else if (sel < 30 || (sel < 55 && held_nodes.size() == 0)) begin
        op = llq_pkg::FUNC_ALLOC;
      end else if (sel < 55) begin
        op = llq_pkg::FUNC_ENQ;
        idx = $urandom_range(0, held_nodes.size() - 1);
        node = held_nodes[idx];
        held_nodes.delete(idx);
      end else if (sel < 78) begin
        op = llq_pkg::FUNC_MOVE;
        pair = pick_pair(1'b0);
      end else begin
        op = llq_pkg::FUNC_REL;
        pair = pick_pair(1'b1);
      end
      send_word(op, node, pair, r);
      if (op == llq_pkg::FUNC_ALLOC && !r.status) held_nodes.push_back(r.node);
    end
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_each_operation();
    test_free_list_exhaustion();
    test_random_ops(470, 0, 0);
    wait_for_results();
    test_random_ops(470, 56, 0);
    wait_for_results();
    test_random_ops(470, 0, 56);
    wait_for_results();
    test_random_ops(470, 25, 25);

    // Let the last words drain, then watch for any stray output.
    wait_for_results();
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
